FILE: hw/rtl/mdad_pkg.sv
package mdad_pkg;

  // Field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ALT_W  = 32;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned RSN_W  = 2;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_DEPLOY_ALT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_TIMEOUT     = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_GAP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_STUCK_WIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_STUCK_RANGE = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_DEPLOY_ALT  = 32'd76800;
  localparam logic [CFG_W-1:0] RST_TIMEOUT     = 32'd120000;
  localparam logic [CFG_W-1:0] RST_MAX_GAP     = 32'd500;
  localparam logic [CFG_W-1:0] RST_STUCK_WIN   = 32'd2000;
  localparam logic [CFG_W-1:0] RST_STUCK_RANGE = 32'd128;

  // Input operation codes
  localparam logic OP_ENTER = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Deploy reason codes
  localparam logic [RSN_W-1:0] RSN_ALT_MET   = 2'd0;
  localparam logic [RSN_W-1:0] RSN_TIMEOUT   = 2'd1;
  localparam logic [RSN_W-1:0] RSN_NOT_MET   = 2'd2;

  // Settings seen by the stuck monitor
  typedef struct packed {
    logic [TIME_W-1:0] max_gap;
    logic [TIME_W-1:0] stuck_win;
    logic [CFG_W-1:0]  stuck_range;
  } mon_cfg_t;

  // Sample handed to the stuck monitor
  typedef struct packed {
    logic              clear;     // enter op: wipe state
    logic              usable;    // sample passed flag and age checks
    logic              finite;
    logic [TIME_W-1:0] stime;
    logic [ALT_W-1:0]  alt;
  } mon_req_t;

endpackage

FILE: hw/rtl/mdad_stuck_mon.sv
// Barometer stuck monitor: min/max window over new usable samples.
module mdad_stuck_mon (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  mdad_pkg::mon_req_t        req,
  input  mdad_pkg::mon_cfg_t        cfg,
  output logic                      stuck
);

  logic [mdad_pkg::TIME_W-1:0] last_seen_r, last_seen_nxt;
  logic                        active_r, active_nxt;
  logic [mdad_pkg::TIME_W-1:0] wstart_r, wstart_nxt;
  logic [mdad_pkg::TIME_W-1:0] lws_r, lws_nxt;
  logic [mdad_pkg::ALT_W-1:0]  wmin_r, wmin_nxt;
  logic [mdad_pkg::ALT_W-1:0]  wmax_r, wmax_nxt;

  logic                        do_track;
  logic                        gap_break;
  logic                        win_done;
  logic [mdad_pkg::ALT_W-1:0]  min_upd, max_upd;
  logic [mdad_pkg::ALT_W:0]    span;
  logic                        in_range;
  logic [mdad_pkg::TIME_W-1:0] gap_dt, win_dt;

  // Only a sample with a new timestamp is tracked
  assign do_track = req.usable && (req.stime != last_seen_r);

  assign gap_dt    = req.stime - lws_r;
  assign win_dt    = req.stime - wstart_r;
  assign gap_break = !active_r || ((lws_r != '0) && (gap_dt > cfg.max_gap));
  assign win_done  = win_dt >= cfg.stuck_win;

  // Extremes including this sample (signed compare)
  assign min_upd = ($signed(req.alt) < $signed(wmin_r)) ? req.alt : wmin_r;
  assign max_upd = ($signed(req.alt) > $signed(wmax_r)) ? req.alt : wmax_r;

  // max >= min always holds, so the 33-bit difference is non-negative
  assign span     = {max_upd[mdad_pkg::ALT_W-1], max_upd}
                  - {min_upd[mdad_pkg::ALT_W-1], min_upd};
  assign in_range = span <= {1'b0, cfg.stuck_range};

  // Next-state logic
  always_comb begin
    last_seen_nxt = last_seen_r;
    active_nxt    = active_r;
    wstart_nxt    = wstart_r;
    lws_nxt       = lws_r;
    wmin_nxt      = wmin_r;
    wmax_nxt      = wmax_r;
    stuck         = 1'b0;
    if (req.clear) begin
      last_seen_nxt = '0;
      active_nxt    = 1'b0;
      wstart_nxt    = '0;
      lws_nxt       = '0;
      wmin_nxt      = '0;
      wmax_nxt      = '0;
    end else if (do_track) begin
      last_seen_nxt = req.stime;
      if (!req.finite) begin
        // non-finite altitude drops the window
        active_nxt = 1'b0;
        wstart_nxt = '0;
        lws_nxt    = '0;
        wmin_nxt   = '0;
        wmax_nxt   = '0;
      end else if (gap_break) begin
        active_nxt = 1'b1;
        wstart_nxt = req.stime;
        lws_nxt    = req.stime;
        wmin_nxt   = req.alt;
        wmax_nxt   = req.alt;
      end else begin
        lws_nxt  = req.stime;
        wmin_nxt = min_upd;
        wmax_nxt = max_upd;
        if (win_done) begin
          if (in_range) begin
            stuck = 1'b1;
          end else begin
            // window elapsed with a wide range: restart here
            wstart_nxt = req.stime;
            wmin_nxt   = req.alt;
            wmax_nxt   = req.alt;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seen_r <= '0;
      active_r    <= 1'b0;
      wstart_r    <= '0;
      lws_r       <= '0;
      wmin_r      <= '0;
      wmax_r      <= '0;
    end else if (en) begin
      last_seen_r <= last_seen_nxt;
      active_r    <= active_nxt;
      wstart_r    <= wstart_nxt;
      lws_r       <= lws_nxt;
      wmin_r      <= wmin_nxt;
      wmax_r      <= wmax_nxt;
    end
  end

endmodule

FILE: hw/rtl/main_deploy_altitude_detector_unit.sv
// Channel   Direction  Handshake              Contents
// in_*      input      in_valid / in_ready    op, times, status flags, altitude
// out_*     output     out_valid / out_ready  deploy_accept, reason, stuck, time since entry
// cfg_*     input      cfg_we                 cfg_index selects register, cfg_wdata
//
// An item is held in the input register and is evaluated against the stuck
// window state as it moves into the output register, which holds the result
// until it transfers out; one item per cycle sustained while out_ready stays
// high.
// An enter op clears the window state and gives no result.
// Synchronous active-low reset clears valids and window state and loads the configuration registers with reset values.
// in_ready follows out_ready when both stages are full, unless the held item is an enter op.
module main_deploy_altitude_detector_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [mdad_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mdad_pkg::CFG_W-1:0]    cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [mdad_pkg::TIME_W-1:0]   in_now_time,
  input  logic [mdad_pkg::TIME_W-1:0]   in_drogue_entry_time,
  input  logic                          in_stuck_latched,
  input  logic                          in_sample_valid,
  input  logic                          in_reference_valid,
  input  logic                          in_status_fault,
  input  logic                          in_sensor_fault,
  input  logic [mdad_pkg::TIME_W-1:0]   in_sample_time,
  input  logic                          in_altitude_finite,
  input  logic signed [mdad_pkg::ALT_W-1:0] in_altitude,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_deploy_accept,
  output logic [mdad_pkg::RSN_W-1:0]    out_reason_code,
  output logic                          out_stuck_fault,
  output logic [mdad_pkg::TIME_W-1:0]   out_time_since_entry
);

  // Configuration registers
  logic [mdad_pkg::CFG_W-1:0] deploy_alt_r, timeout_r, max_gap_r, stuck_win_r, stuck_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deploy_alt_r  <= mdad_pkg::RST_DEPLOY_ALT;
      timeout_r     <= mdad_pkg::RST_TIMEOUT;
      max_gap_r     <= mdad_pkg::RST_MAX_GAP;
      stuck_win_r   <= mdad_pkg::RST_STUCK_WIN;
      stuck_range_r <= mdad_pkg::RST_STUCK_RANGE;
    end else if (cfg_we) begin
      case (cfg_index)
        mdad_pkg::REG_DEPLOY_ALT:  deploy_alt_r  <= cfg_wdata;
        mdad_pkg::REG_TIMEOUT:     timeout_r     <= cfg_wdata;
        mdad_pkg::REG_MAX_GAP:     max_gap_r     <= cfg_wdata;
        mdad_pkg::REG_STUCK_WIN:   stuck_win_r   <= cfg_wdata;
        mdad_pkg::REG_STUCK_RANGE: stuck_range_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  logic                        s1_valid_r;
  logic                        s1_op_r;
  logic [mdad_pkg::TIME_W-1:0] s1_now_r, s1_entry_r, s1_stime_r;
  logic                        s1_latched_r, s1_svalid_r, s1_rvalid_r;
  logic                        s1_sfault_r, s1_efault_r, s1_finite_r;
  logic [mdad_pkg::ALT_W-1:0]  s1_alt_r;

  logic s1_adv;
  logic out_valid_r;

  // Stage 1 moves on when the result slot is free or drains this cycle;
  // an enter op needs no slot
  assign s1_adv   = s1_valid_r && ((s1_op_r == mdad_pkg::OP_ENTER) || !out_valid_r
                                   || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r      <= in_op;
      s1_now_r     <= in_now_time;
      s1_entry_r   <= in_drogue_entry_time;
      s1_latched_r <= in_stuck_latched;
      s1_svalid_r  <= in_sample_valid;
      s1_rvalid_r  <= in_reference_valid;
      s1_sfault_r  <= in_status_fault;
      s1_efault_r  <= in_sensor_fault;
      s1_stime_r   <= in_sample_time;
      s1_finite_r  <= in_altitude_finite;
      s1_alt_r     <= in_altitude;
    end
  end

  // Sample qualification by flags and age
  logic [mdad_pkg::TIME_W-1:0] age;
  logic                        usable_pre;

  assign age        = s1_now_r - s1_stime_r;
  assign usable_pre = !s1_latched_r && s1_svalid_r && s1_rvalid_r && !s1_sfault_r
                    && !s1_efault_r && (s1_stime_r != '0) && (age <= max_gap_r);

  // Stuck monitor
  mdad_pkg::mon_req_t mon_req;
  mdad_pkg::mon_cfg_t mon_cfg;
  logic               stuck;

  always_comb begin
    mon_req.clear       = (s1_op_r == mdad_pkg::OP_ENTER);
    mon_req.usable      = usable_pre;
    mon_req.finite      = s1_finite_r;
    mon_req.stime       = s1_stime_r;
    mon_req.alt         = s1_alt_r;
    mon_cfg.max_gap     = max_gap_r;
    mon_cfg.stuck_win   = stuck_win_r;
    mon_cfg.stuck_range = stuck_range_r;
  end

  mdad_stuck_mon u_stuck_mon (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_adv),
    .req   (mon_req),
    .cfg   (mon_cfg),
    .stuck (stuck)
  );

  // Deploy decision
  logic [mdad_pkg::TIME_W-1:0] elapsed;
  logic                        reached, timed_out;
  logic [mdad_pkg::RSN_W-1:0]  reason;

  assign elapsed   = s1_now_r - s1_entry_r;
  assign reached   = usable_pre && !stuck && s1_finite_r
                   && ($signed(s1_alt_r) <= $signed(deploy_alt_r));
  assign timed_out = elapsed >= timeout_r;

  always_comb begin
    if (reached) begin
      reason = mdad_pkg::RSN_ALT_MET;
    end else if (timed_out) begin
      reason = mdad_pkg::RSN_TIMEOUT;
    end else begin
      reason = mdad_pkg::RSN_NOT_MET;
    end
  end

  // Result register
  logic                        load_out;
  logic                        accept_r, stuck_r;
  logic [mdad_pkg::RSN_W-1:0]  reason_r;
  logic [mdad_pkg::TIME_W-1:0] elapsed_r;

  assign load_out = s1_adv && (s1_op_r == mdad_pkg::OP_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      accept_r  <= reached || timed_out;
      reason_r  <= reason;
      stuck_r   <= stuck;
      elapsed_r <= elapsed;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_deploy_accept    = accept_r;
  assign out_reason_code      = reason_r;
  assign out_stuck_fault      = stuck_r;
  assign out_time_since_entry = elapsed_r;

endmodule

FILE: test/tb_main_deploy_altitude_detector_unit.sv
module tb_main_deploy_altitude_detector_unit;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SHOW_LIMIT  = 10;

  // One barometer step as offered on the input channel
  typedef struct {
    logic                               op;
    logic [mdad_pkg::TIME_W-1:0]        now_t;
    logic [mdad_pkg::TIME_W-1:0]        entry_t;
    logic                               latched;
    logic                               svalid;
    logic                               rvalid;
    logic                               sfault;
    logic                               efault;
    logic [mdad_pkg::TIME_W-1:0]        stime;
    logic                               finite;
    logic signed [mdad_pkg::ALT_W-1:0]  alt;
  } baro_item_t;

  // Deploy decision as carried by the result channel
  typedef struct {
    logic                        accept;
    logic [mdad_pkg::RSN_W-1:0]  reason;
    logic                        stuck;
    logic [mdad_pkg::TIME_W-1:0] elapsed;
  } deploy_verdict_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [mdad_pkg::IDX_W-1:0]        cfg_index = '0;
  logic [mdad_pkg::CFG_W-1:0]        cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_op = mdad_pkg::OP_ENTER;
  logic [mdad_pkg::TIME_W-1:0]       in_now_time = '0;
  logic [mdad_pkg::TIME_W-1:0]       in_drogue_entry_time = '0;
  logic                              in_stuck_latched = 1'b0;
  logic                              in_sample_valid = 1'b0;
  logic                              in_reference_valid = 1'b0;
  logic                              in_status_fault = 1'b0;
  logic                              in_sensor_fault = 1'b0;
  logic [mdad_pkg::TIME_W-1:0]       in_sample_time = '0;
  logic                              in_altitude_finite = 1'b0;
  logic signed [mdad_pkg::ALT_W-1:0] in_altitude = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_deploy_accept;
  logic [mdad_pkg::RSN_W-1:0]        out_reason_code;
  logic                              out_stuck_fault;
  logic [mdad_pkg::TIME_W-1:0]       out_time_since_entry;

  main_deploy_altitude_detector_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_now_time          (in_now_time),
    .in_drogue_entry_time (in_drogue_entry_time),
    .in_stuck_latched     (in_stuck_latched),
    .in_sample_valid      (in_sample_valid),
    .in_reference_valid   (in_reference_valid),
    .in_status_fault      (in_status_fault),
    .in_sensor_fault      (in_sensor_fault),
    .in_sample_time       (in_sample_time),
    .in_altitude_finite   (in_altitude_finite),
    .in_altitude          (in_altitude),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_deploy_accept    (out_deploy_accept),
    .out_reason_code      (out_reason_code),
    .out_stuck_fault      (out_stuck_fault),
    .out_time_since_entry (out_time_since_entry)
  );

  // Predictor copy of the registers
  logic signed [mdad_pkg::ALT_W-1:0] thr_alt;
  logic [mdad_pkg::CFG_W-1:0]        thr_timeout;
  logic [mdad_pkg::CFG_W-1:0]        max_gap;
  logic [mdad_pkg::CFG_W-1:0]        win_len;
  logic [mdad_pkg::CFG_W-1:0]        win_range;

  // Predictor copy of the stuck monitor
  logic [mdad_pkg::TIME_W-1:0]       seen_stime;
  logic                              win_open;
  logic [mdad_pkg::TIME_W-1:0]       win_start;
  logic [mdad_pkg::TIME_W-1:0]       win_last;
  logic signed [mdad_pkg::ALT_W-1:0] win_lo;
  logic signed [mdad_pkg::ALT_W-1:0] win_hi;

  deploy_verdict_t pending_verdicts[$];
  deploy_verdict_t want_v;

  int  n_err = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_writes = 0;
  int  n_stuck = 0;
  int  n_alt = 0;
  int  n_timeout = 0;
  int  cycles = 0;
  int  hold_req = 0;
  bit  hold_on = 1'b0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d results outstanding",
               cycles, pending_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one
  function automatic int idle_cycles();
    return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function void close_window();
    win_open  = 1'b0;
    win_start = '0;
    win_last  = '0;
    win_lo    = '0;
    win_hi    = '0;
  endfunction

  // Min/max window over new samples; returns 1 when the sensor looks stuck
  function automatic bit update_stuck_window(input logic [mdad_pkg::TIME_W-1:0] t,
                                             input logic fin,
                                             input logic signed [mdad_pkg::ALT_W-1:0] a);
    logic [mdad_pkg::TIME_W-1:0] since_last;
    logic [mdad_pkg::TIME_W-1:0] open_for;
    longint                      spread;
    if (!fin) begin
      close_window();
      return 1'b0;
    end
    since_last = t - win_last;
    if (!win_open || (win_last != '0 && since_last > max_gap)) begin
      win_open  = 1'b1;
      win_start = t;
      win_last  = t;
      win_lo    = a;
      win_hi    = a;
      return 1'b0;
    end
    if (a < win_lo) win_lo = a;
    if (a > win_hi) win_hi = a;
    win_last = t;
    open_for = t - win_start;
    if (open_for >= win_len) begin
      spread = longint'(win_hi) - longint'(win_lo);
      if (spread <= longint'(win_range)) return 1'b1;
      // too lively: restart the window here
      win_start = t;
      win_lo    = a;
      win_hi    = a;
    end
    return 1'b0;
  endfunction

  // Expected decision for one step; returns 0 for an enter op
  function automatic bit predict_deploy(input baro_item_t s, output deploy_verdict_t v);
    logic                        ok;
    logic                        stuck;
    logic                        reached;
    logic                        late;
    logic [mdad_pkg::TIME_W-1:0] age;
    logic [mdad_pkg::TIME_W-1:0] el;
    stuck = 1'b0;
    v = '{default: '0};
    if (s.op == mdad_pkg::OP_ENTER) begin
      seen_stime = '0;
      close_window();
      return 1'b0;
    end
    age = s.now_t - s.stime;
    ok = !s.latched && s.svalid && s.rvalid && !s.sfault && !s.efault &&
         s.stime != '0 && age <= max_gap;
    if (ok && s.stime != seen_stime) begin
      seen_stime = s.stime;
      stuck = update_stuck_window(s.stime, s.finite, s.alt);
      if (stuck) ok = 1'b0;
    end
    el      = s.now_t - s.entry_t;
    reached = ok && s.finite && (s.alt <= thr_alt);
    late    = el >= thr_timeout;
    v.accept  = reached || late;
    v.reason  = reached ? mdad_pkg::RSN_ALT_MET
                        : (late ? mdad_pkg::RSN_TIMEOUT : mdad_pkg::RSN_NOT_MET);
    v.stuck   = stuck;
    v.elapsed = el;
    return 1'b1;
  endfunction

  function automatic baro_item_t good_sample(input logic [mdad_pkg::TIME_W-1:0] now_t,
                                             input logic [mdad_pkg::TIME_W-1:0] stime,
                                             input logic signed [mdad_pkg::ALT_W-1:0] alt);
    baro_item_t s;
    s.op      = mdad_pkg::OP_EVAL;
    s.now_t   = now_t;
    s.entry_t = now_t;
    s.latched = 1'b0;
    s.svalid  = 1'b1;
    s.rvalid  = 1'b1;
    s.sfault  = 1'b0;
    s.efault  = 1'b0;
    s.stime   = stime;
    s.finite  = 1'b1;
    s.alt     = alt;
    return s;
  endfunction

  function automatic baro_item_t noise_sample();
    baro_item_t s;
    s.op      = ($urandom_range(0, 3) == 0) ? mdad_pkg::OP_ENTER : mdad_pkg::OP_EVAL;
    s.now_t   = $urandom;
    s.entry_t = $urandom;
    s.latched = 1'($urandom_range(0, 1));
    s.svalid  = 1'($urandom_range(0, 1));
    s.rvalid  = 1'($urandom_range(0, 1));
    s.sfault  = 1'($urandom_range(0, 1));
    s.efault  = 1'($urandom_range(0, 1));
    s.stime   = $urandom;
    s.finite  = 1'($urandom_range(0, 1));
    s.alt     = $urandom;
    return s;
  endfunction

  task automatic flag_error(input string msg);
    n_err++;
    if (n_err <= SHOW_LIMIT) $display("mismatch: %s", msg);
  endtask

  // Offer one step, hold it until the transfer, then maybe pause
  task automatic send_item(input baro_item_t s);
    deploy_verdict_t v;
    in_op                <= s.op;
    in_now_time          <= s.now_t;
    in_drogue_entry_time <= s.entry_t;
    in_stuck_latched     <= s.latched;
    in_sample_valid      <= s.svalid;
    in_reference_valid   <= s.rvalid;
    in_status_fault      <= s.sfault;
    in_sensor_fault      <= s.efault;
    in_sample_time       <= s.stime;
    in_altitude_finite   <= s.finite;
    in_altitude          <= s.alt;
    in_valid             <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    if (predict_deploy(s, v)) pending_verdicts.push_back(v);
    if (tx_idle && $urandom_range(0, 1) == 1) begin
      in_valid <= 1'b0;
      repeat (idle_cycles()) @(posedge clk);
    end
  endtask

  // Sender pause until every decision is back and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mdad_pkg::IDX_W-1:0] idx,
                           input logic [mdad_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    n_writes++;
    case (idx)
      mdad_pkg::REG_DEPLOY_ALT:  thr_alt     = val;
      mdad_pkg::REG_TIMEOUT:     thr_timeout = val;
      mdad_pkg::REG_MAX_GAP:     max_gap     = val;
      mdad_pkg::REG_STUCK_WIN:   win_len     = val;
      mdad_pkg::REG_STUCK_RANGE: win_range   = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [mdad_pkg::CFG_W-1:0] alt,
                            input logic [mdad_pkg::CFG_W-1:0] tmo,
                            input logic [mdad_pkg::CFG_W-1:0] gap,
                            input logic [mdad_pkg::CFG_W-1:0] win,
                            input logic [mdad_pkg::CFG_W-1:0] rng);
    wait_idle();
    write_reg(mdad_pkg::REG_DEPLOY_ALT, alt);
    write_reg(mdad_pkg::REG_TIMEOUT, tmo);
    write_reg(mdad_pkg::REG_MAX_GAP, gap);
    write_reg(mdad_pkg::REG_STUCK_WIN, win);
    write_reg(mdad_pkg::REG_STUCK_RANGE, rng);
  endtask

  // One descent after drogue: enter op, then a stream of mostly good samples
  // with some flag faults, stale or repeated times, gaps and stray noise.
  // A steady flight keeps the altitude nearly flat to provoke stuck faults.
  task automatic run_flight(input int n, input bit steady);
    baro_item_t                        s;
    logic [mdad_pkg::TIME_W-1:0]       pace;
    logic [mdad_pkg::TIME_W-1:0]       now_t;
    logic [mdad_pkg::TIME_W-1:0]       entry_t;
    logic [mdad_pkg::TIME_W-1:0]       prev_stime;
    logic signed [mdad_pkg::ALT_W-1:0] base;
    int                                r;
    pace  = (max_gap > 2000) ? 400 : max_gap;
    now_t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
    r = $urandom_range(0, 2);
    if (r == 0)      entry_t = now_t;
    else if (r == 1) entry_t = now_t - (thr_timeout - $urandom_range(0, 40 * pace + 100));
    else             entry_t = $urandom;
    base = thr_alt + $urandom_range(0, 6000) - 2000;
    prev_stime = '0;
    s = noise_sample();
    s.op = mdad_pkg::OP_ENTER;
    send_item(s);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(noise_sample());
      end else begin
        now_t = now_t + $urandom_range(1, pace / 2 + 1);
        if ($urandom_range(0, 39) == 0) now_t = now_t + 3 * pace + 50;
        s = good_sample(now_t, now_t - $urandom_range(0, pace / 4), base);
        s.entry_t = entry_t;
        if (prev_stime != '0 && $urandom_range(0, 11) == 0) s.stime = prev_stime;
        if ($urandom_range(0, 24) == 0) s.stime = now_t - max_gap - 1 - $urandom_range(0, 20);
        if ($urandom_range(0, 49) == 0) s.stime = '0;
        if (!steady) base = base - $urandom_range(0, 300);
        s.alt     = base + (steady ? $urandom_range(0, 96) : $urandom_range(0, 3000));
        s.latched = ($urandom_range(0, 29) == 0);
        s.svalid  = ($urandom_range(0, 29) != 0);
        s.rvalid  = ($urandom_range(0, 29) != 0);
        s.sfault  = ($urandom_range(0, 29) == 0);
        s.efault  = ($urandom_range(0, 29) == 0);
        s.finite  = ($urandom_range(0, 29) != 0);
        send_item(s);
        if (s.stime != '0) prev_stime = s.stime;
      end
    end
  endtask

  // Hand-picked steps under the reset settings
  task automatic test_directed();
    baro_item_t s;
    s = good_sample(32'd10, 32'd5, 32'sd0);
    s.op = mdad_pkg::OP_ENTER;
    send_item(s);
    // no sample at all
    send_item(good_sample(32'd1000, 32'd0, 32'sd0));
    // top of every field, elapsed at its maximum
    s = good_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    s.entry_t = '0;
    send_item(s);
    // lowest altitude, sample time wrapped past zero
    send_item(good_sample(32'd50, 32'd40, 32'sh8000_0000));
    s = good_sample(32'd100, 32'd90, 32'sd0);
    s.finite = 1'b0;
    send_item(s);
    s = good_sample(32'd200, 32'd190, 32'sd0);
    s.latched = 1'b1;
    send_item(s);
    s = good_sample(32'd300, 32'd290, 32'sd0);
    s.svalid = 1'b0;
    send_item(s);
    s = good_sample(32'd400, 32'd390, 32'sd0);
    s.rvalid = 1'b0;
    send_item(s);
    s = good_sample(32'd500, 32'd490, 32'sd0);
    s.sfault = 1'b1;
    send_item(s);
    s = good_sample(32'd600, 32'd590, 32'sd0);
    s.efault = 1'b1;
    send_item(s);
    // stale sample
    send_item(good_sample(32'd2000, 32'd1000, 32'sd0));
    // threshold and timeout together, then the same sample time again
    s = good_sample(32'd130000, 32'd129900, 32'sd0);
    s.entry_t = '0;
    send_item(s);
    s.now_t = 32'd130100;
    send_item(s);
    // flat altitude over a full window: stuck on the sixth sample
    s.op = mdad_pkg::OP_ENTER;
    send_item(s);
    for (int k = 0; k < 6; k++)
      send_item(good_sample(1010 + 400 * k, 1000 + 400 * k, thr_alt + ((k + 1) % 2) * 50));
    // window kept after the fault, now too wide so it restarts
    send_item(good_sample(32'd3410, 32'd3400, 32'sd200000));
    // gap too long: window reopens
    send_item(good_sample(32'd4410, 32'd4400, 32'sd200000));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_config(32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int f = 0; f < 4; f++) run_flight(30, f[0]);
    set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int f = 0; f < 4; f++) run_flight(30, f[0]);
  endtask

  task automatic test_random_flights();
    set_config(32'd40000, 32'd3000, 32'd40, 32'd150, 32'd64);
    for (int f = 0; f < 7; f++) run_flight(35, 1'($urandom_range(0, 1)));
    set_config(mdad_pkg::RST_DEPLOY_ALT, mdad_pkg::RST_TIMEOUT, mdad_pkg::RST_MAX_GAP,
               mdad_pkg::RST_STUCK_WIN, mdad_pkg::RST_STUCK_RANGE);
    for (int f = 0; f < 5; f++) run_flight(45, 1'($urandom_range(0, 1)));
    for (int c = 0; c < 3; c++) begin
      set_config($urandom, $urandom_range(0, 5000), $urandom_range(1, 600),
                 $urandom_range(0, 3000), $urandom_range(0, 400));
      for (int f = 0; f < 3; f++) run_flight(35, 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_input_stall();
    wait_idle();
    tx_idle  = 1'b0;
    hold_req = 300;
    while (!hold_on) @(posedge clk);
    run_flight(60, 1'b1);
    wait_idle();
    tx_idle = 1'b1;
    run_flight(30, 1'b0);
    wait_idle();
  endtask

  // Back-to-back transfers with the receiver always ready
  task automatic test_full_rate();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int f = 0; f < 4; f++) run_flight(35, 1'($urandom_range(0, 1)));
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Result side: random ready pattern, plus long holds on request
  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      hold_on = 1'b0;
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
        hold_on  = 1'b1;
        out_ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        hold = idle_cycles();
        out_ready <= 1'b0;
      end else begin
        hold = $urandom_range(1, 6);
        out_ready <= 1'b1;
      end
      repeat (hold) @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest expected decision
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want_v = pending_verdicts.pop_front();
        if (out_deploy_accept !== want_v.accept)
          flag_error($sformatf("result %0d deploy_accept: expected %0d, got %0d",
                               n_results, want_v.accept, out_deploy_accept));
        if (out_reason_code !== want_v.reason)
          flag_error($sformatf("result %0d reason_code: expected %0d, got %0d",
                               n_results, want_v.reason, out_reason_code));
        if (out_stuck_fault !== want_v.stuck)
          flag_error($sformatf("result %0d stuck_fault: expected %0d, got %0d",
                               n_results, want_v.stuck, out_stuck_fault));
        if (out_time_since_entry !== want_v.elapsed)
          flag_error($sformatf("result %0d time_since_entry: expected %h, got %h",
                               n_results, want_v.elapsed, out_time_since_entry));
        if (want_v.stuck) n_stuck++;
        if (want_v.reason == mdad_pkg::RSN_ALT_MET) n_alt++;
        else if (want_v.reason == mdad_pkg::RSN_TIMEOUT) n_timeout++;
      end
    end
  end

  initial begin : main_seq
    int drain;
    thr_alt     = mdad_pkg::RST_DEPLOY_ALT;
    thr_timeout = mdad_pkg::RST_TIMEOUT;
    max_gap     = mdad_pkg::RST_MAX_GAP;
    win_len     = mdad_pkg::RST_STUCK_WIN;
    win_range   = mdad_pkg::RST_STUCK_RANGE;
    seen_stime  = '0;
    close_window();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_register_extremes();
    test_random_flights();
    test_input_stall();
    test_full_rate();

    // final drain, bounded
    drain = 0;
    while (pending_verdicts.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (pending_verdicts.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_verdicts.size()));

    $display("Covered %0d input transfers, %0d results, %0d register writes.",
             n_items, n_results, n_writes);
    $display("Saw %0d stuck faults, %0d altitude and %0d timeout deploys; %0d mismatches.",
             n_stuck, n_alt, n_timeout, n_err);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
